// File: src/rsx_pkg.sv
// ----------------------------------------------------------------------------
// rsx_pkg - shared types and constants of the RLE / sysex 7-bit encoder
// Holds the group geometry, the function codes and the job record that moves
// from the classifying front end to the output serializer.
// ----------------------------------------------------------------------------
package rsx_pkg;

  // Data bytes per 7-bit group; a group is one header plus this many bytes
  localparam int GROUP_SIZE      = 7;
  // Most results one item can cause: a full group plus a flushed pair
  localparam int RES_MAX         = 10;
  localparam int MAX_RUN_DEF     = 127;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam logic [15:0] CAP_RESET = 16'hFFFF;

  // Input function codes
  localparam logic FUNC_DATA   = 1'b0;
  localparam logic FUNC_FINISH = 1'b1;

  typedef logic [6:0] sbyte_t;

  // Results of one item, in output order
  typedef struct packed {
    sbyte_t [RES_MAX-1:0] lst;    // encoded bytes, first result in entry 0
    logic   [3:0]         cnt;    // number of results, 1 to RES_MAX
    logic                 vld;    // 0 for a length-only result
    logic   [15:0]        total;  // reported on the last result
    logic                 ovf;    // sticky error after this item
  } rsx_job_t;

endpackage

// File: src/rsx_front.sv
// ----------------------------------------------------------------------------
// rsx_front - run tracking, group packing and capacity check
// Takes one item per cycle, closes runs, drops bytes beyond capacity, and
// builds the complete result list of the item as one job for the queue.
// ----------------------------------------------------------------------------
module rsx_front import rsx_pkg::*; #(
  parameter int MAX_RUN = MAX_RUN_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data,
  input  logic         in_fire,
  input  logic         in_func,
  input  logic [7:0]   in_byte,
  output logic         push,
  output rsx_job_t     job
);

  localparam logic [6:0] MAX_RUN_W = 7'(MAX_RUN);
  localparam logic [2:0] LAST_SLOT = 3'(GROUP_SIZE - 1);

  logic [15:0]              cap_r;
  sbyte_t [GROUP_SIZE-1:0]  bytes_r, bytes_nxt;
  logic [6:0]               hdr_r, hdr_nxt;
  logic [2:0]               fill_r, fill_nxt;
  logic [15:0]              wc_r, wc_nxt;
  logic                     err_r, err_nxt;
  logic [7:0]               run_val_r, run_val_nxt;
  logic [6:0]               run_cnt_r, run_cnt_nxt;
  logic                     await_r, await_nxt;

  logic                     fin;
  logic [6:0]               cnt_inc;
  logic [6:0]               cls_cnt;
  logic [1:0]               n_put;
  logic [1:0][7:0]          pb;
  logic [15:0]              nb;
  logic [1:0]               room;
  logic                     a_done;
  logic [6:0]               a_hdr;
  sbyte_t [GROUP_SIZE-1:0]  a_bytes;
  logic                     part;
  logic [3:0]               res_cnt;

  assign fin     = (in_func == FUNC_FINISH);
  assign cnt_inc = run_cnt_r + 7'd1;
  assign nb      = wc_r + 16'(fill_r);
  // Both bytes of a pair are checked against capacity at once; when the
  // first byte closes a group, the header moves the second one up by one
  assign room[0] = (17'(nb) + 17'd1) < 17'(cap_r);
  assign room[1] = (17'(nb) + ((fill_r == LAST_SLOT) ? 17'd3 : 17'd2)) < 17'(cap_r);

  // Run tracking: decide which run closes and the next run state
  always_comb begin
    run_val_nxt = run_val_r;
    run_cnt_nxt = run_cnt_r;
    await_nxt   = await_r;
    cls_cnt     = '0;
    if (fin) begin
      cls_cnt = run_cnt_r;
    end else if (await_r) begin
      run_val_nxt = in_byte;
      run_cnt_nxt = 7'd1;
      await_nxt   = 1'b0;
    end else if (in_byte == run_val_r) begin
      run_cnt_nxt = cnt_inc;
      if (cnt_inc >= MAX_RUN_W) begin
        cls_cnt     = cnt_inc;
        run_cnt_nxt = '0;
      end
    end else begin
      cls_cnt     = run_cnt_r;
      run_val_nxt = in_byte;
      run_cnt_nxt = 7'd1;
    end
  end

  // Encode the closed run as zero, one or two bytes
  always_comb begin
    n_put = 2'd0;
    pb[0] = run_val_r;
    pb[1] = run_val_r;
    if (cls_cnt == '0) begin
      n_put = 2'd0;
    end else if (cls_cnt == 7'd1 && !run_val_r[7]) begin
      n_put = 2'd1;
    end else begin
      n_put = 2'd2;
      pb[0] = {1'b1, cls_cnt};
    end
  end

  // Pack the bytes into the group, snapshot a group that fills up
  always_comb begin
    hdr_nxt   = hdr_r;
    bytes_nxt = bytes_r;
    fill_nxt  = fill_r;
    wc_nxt    = wc_r;
    err_nxt   = err_r;
    a_done    = 1'b0;
    a_hdr     = hdr_r;
    a_bytes   = bytes_r;
    for (int k = 0; k < 2; k++) begin
      if (2'(k) < n_put) begin
        if (room[k]) begin
          if (fill_nxt == '0) begin
            hdr_nxt = '0;
          end
          hdr_nxt[LAST_SLOT - fill_nxt] = pb[k][7];
          bytes_nxt[fill_nxt] = pb[k][6:0];
          if (fill_nxt == LAST_SLOT) begin
            a_done   = 1'b1;
            a_hdr    = hdr_nxt;
            a_bytes  = bytes_nxt;
            fill_nxt = '0;
            wc_nxt   = wc_nxt + 16'(GROUP_SIZE + 1);
          end else begin
            fill_nxt = fill_nxt + 3'd1;
          end
        end else begin
          err_nxt = 1'b1;
        end
      end
    end
  end

  // Build the result list of the item
  always_comb begin
    job     = '0;
    part    = fin && (fill_nxt != '0);
    res_cnt = (a_done ? 4'd8 : 4'd0) + (part ? 4'(fill_nxt) + 4'd1 : 4'd0);
    if (a_done) begin
      job.lst[0] = a_hdr;
      for (int i = 0; i < GROUP_SIZE; i++) begin
        job.lst[i+1] = a_bytes[i];
      end
      // a group that fills leaves at most one byte in the next one
      job.lst[GROUP_SIZE+1] = hdr_nxt;
      job.lst[GROUP_SIZE+2] = bytes_nxt[0];
    end else begin
      job.lst[0] = hdr_nxt;
      for (int i = 0; i < GROUP_SIZE; i++) begin
        job.lst[i+1] = bytes_nxt[i];
      end
    end
    job.cnt = res_cnt;
    job.vld = 1'b1;
    if (res_cnt == '0) begin
      job.cnt    = 4'd1;
      job.vld    = 1'b0;
      job.lst[0] = '0;
    end
    job.ovf = err_nxt;
    if (fin && !err_nxt) begin
      job.total = wc_nxt + ((fill_nxt != '0) ? 16'(fill_nxt) + 16'd1 : 16'd0);
    end
    push = in_fire && (a_done || fin);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r     <= '0;
      fill_r    <= '0;
      wc_r      <= '0;
      err_r     <= 1'b0;
      run_val_r <= '0;
      run_cnt_r <= '0;
      await_r   <= 1'b1;
    end else if (in_fire) begin
      if (fin) begin
        hdr_r     <= '0;
        fill_r    <= '0;
        wc_r      <= '0;
        err_r     <= 1'b0;
        run_val_r <= '0;
        run_cnt_r <= '0;
        await_r   <= 1'b1;
      end else begin
        hdr_r     <= hdr_nxt;
        fill_r    <= fill_nxt;
        wc_r      <= wc_nxt;
        err_r     <= err_nxt;
        run_val_r <= run_val_nxt;
        run_cnt_r <= run_cnt_nxt;
        await_r   <= await_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      bytes_r <= bytes_nxt;
    end
  end

endmodule

// File: src/rsx_queue.sv
// ----------------------------------------------------------------------------
// rsx_queue - short job queue between front end and serializer
// Register-based FIFO of result lists; the head entry is read in place.
// ----------------------------------------------------------------------------
module rsx_queue import rsx_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  rsx_job_t  push_job,
  input  logic      pop,
  output rsx_job_t  head,
  output logic      empty,
  output logic      full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  rsx_job_t          slots_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CNT_FULL);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue count beyond depth");

endmodule

// File: src/rsx_back.sv
// ----------------------------------------------------------------------------
// rsx_back - result serializer
// Walks the head job one result per ready cycle, releasing it after the last.
// ----------------------------------------------------------------------------
module rsx_back import rsx_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  rsx_job_t     head,
  input  logic         empty,
  output logic         pop,
  input  logic         out_tready,
  output logic         out_tvalid,
  output logic [23:0]  out_tdata,
  output logic         out_tuser,
  output logic         out_tlast
);

  logic [3:0] idx_r, idx_nxt;
  logic       last;
  logic       fire;

  assign last       = (idx_r == head.cnt - 4'd1);
  assign out_tvalid = !empty;
  assign fire       = out_tvalid && out_tready;
  assign pop        = fire && last;
  assign out_tlast  = last;
  assign out_tuser  = head.vld;
  assign out_tdata  = {head.ovf, (last ? head.total : 16'd0), head.lst[idx_r]};

  always_comb begin
    idx_nxt = idx_r;
    if (fire) begin
      idx_nxt = last ? '0 : idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (idx_r < head.cnt))
    else $error("result index past end of job");

endmodule

// File: src/rle_sysex_7bit_encoder_unit.sv
// ----------------------------------------------------------------------------
// rle_sysex_7bit_encoder_unit - run-length encoder with sysex 7-bit packing
// Front end classifies bytes into runs and groups, a job queue decouples it
// from the serializer that sends one result per cycle while out_tready is high.
//
//   channel   dir   handshake               payload
//   in_       in    in_tvalid/in_tready     tdata: data_byte; tuser: func
//   out_      out   out_tvalid/out_tready   tdata: out_byte, total_length,
//                                           overflow; tuser: out_valid;
//                                           tlast: out_last
//   cfg_      in    cfg_wr_en               cfg_wr_data: capacity_bytes
//
// The front end takes one item per cycle while the job queue has room; each
// item is fully classified in its accept cycle.
// The serializer sends one result per cycle while out_tready is high: a data
// item that fills a group yields 8 results, a finish up to 10, other data items none.
// Sustained rate is set by the serializer's single output port.
// Reset is synchronous; capacity resets to 65535, no clearing pass is needed.
// out_tready low stalls only the serializer until the queue fills.
// ----------------------------------------------------------------------------
module rle_sysex_7bit_encoder_unit import rsx_pkg::*; #(
  parameter int MAX_RUN     = MAX_RUN_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tuser,   // [0] func
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [23:0]  out_tdata,  // [6:0] out_byte, [22:7] total_length, [23] overflow
  output logic         out_tuser,  // [0] out_valid
  output logic         out_tlast
);

  rsx_job_t  push_job;
  rsx_job_t  head;
  logic      push;
  logic      pop;
  logic      q_empty;
  logic      q_full;
  logic      in_fire;

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  rsx_front #(
    .MAX_RUN (MAX_RUN)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_fire     (in_fire),
    .in_func     (in_tuser),
    .in_byte     (in_tdata),
    .push        (push),
    .job         (push_job)
  );

  rsx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  rsx_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .empty      (q_empty),
    .pop        (pop),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_len_only_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> out_tlast)
    else $error("length-only result not last");

  a_len_only_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[6:0] == 7'd0))
    else $error("length-only result carries a byte");

  a_total_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_tdata[22:7] == 16'd0))
    else $error("total length on a result that is not last");

endmodule
